// ===== rtl/core/cpq_pkg.sv =====
// Shared types and constants for the circular process-id queue.
// Holds sizes, operation and status codes, and the controller/datapath
// command and status structs. No dependencies.
package cpq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int ID_W   = 31;
  localparam int OP_W   = 2;
  localparam int ST_W   = 2;

  typedef enum logic [OP_W-1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_SWAP = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  // Selects what goes into the output word when the controller emits.
  typedef enum logic [2:0] {
    RES_ENQ,
    RES_FULL,
    RES_EMPTY,
    RES_HEAD,
    RES_ID,
    RES_OLD,
    RES_NOTF
  } res_t;

  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_scan;
    logic enq;
    logic deq;
    logic wr_head;
    logic wr_found;
    logic old_ld;
    logic found_ld;
    logic emit;
    res_t res;
  } cpq_cmd_t;

  typedef struct packed {
    op_t  op;
    logic empty;
    logic full;
    logic one;
    logic hit;
    logic scan_end;
  } cpq_sts_t;

endpackage

// ===== rtl/core/cpq_dp.sv =====
// Datapath of the circular process-id queue: slot memory, valid bits,
// head/tail/count registers, swap search pointer and the output word.
// Depends on cpq_pkg.
module cpq_dp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cpq_pkg::cpq_cmd_t        cmd,
  input  logic [cpq_pkg::OP_W-1:0] in_op,
  input  logic [cpq_pkg::ID_W-1:0] in_proc_id,
  output cpq_pkg::cpq_sts_t        sts,
  output logic [cpq_pkg::ST_W-1:0] out_status,
  output logic [cpq_pkg::ID_W-1:0] out_value,
  output logic [cpq_pkg::CNT_W-1:0] out_count
);
  import cpq_pkg::*;

  logic [ID_W-1:0]   mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;

  op_t               op_r;
  logic [ID_W-1:0]   id_r;
  logic [ID_W-1:0]   old_r;
  logic [ID_W-1:0]   rdata_r;
  logic              rvld_r;
  logic [ADDR_W-1:0] raddr_r;
  logic [ADDR_W-1:0] scan_r;
  logic [ADDR_W-1:0] found_r;

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [ADDR_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              empty_r, empty_nxt;

  logic [ST_W-1:0]   out_status_r;
  logic [ID_W-1:0]   out_value_r;
  logic [CNT_W-1:0]  out_count_r;

  logic [ADDR_W-1:0] head_inc, tail_inc;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [ID_W-1:0]   wr_data;
  logic [ID_W-1:0]   rd_word;
  logic              wr_en;
  logic              last;
  logic              clear_all;
  logic              deq_one;

  assign head_inc  = (head_r == ADDR_W'(DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign tail_inc  = (tail_r == ADDR_W'(DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign last      = (head_r == tail_r);
  assign clear_all = cmd.deq & last;
  assign deq_one   = cmd.deq & ~last;

  // A slot whose valid bit is clear reads as zero.
  assign rd_word = rvld_r ? rdata_r : '0;
  assign rd_addr = cmd.rd_scan ? scan_r : head_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    cnt_nxt   = cnt_r;
    empty_nxt = empty_r;
    if (cmd.enq) begin
      if (empty_r) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        empty_nxt = 1'b0;
      end else begin
        tail_nxt = tail_inc;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.deq) begin
      if (last) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        cnt_nxt   = '0;
        empty_nxt = 1'b1;
      end else begin
        head_nxt = head_inc;
        cnt_nxt  = cnt_r - 1'b1;
      end
    end
  end

  always_comb begin
    wr_en   = cmd.enq | cmd.wr_head | cmd.wr_found;
    wr_data = cmd.wr_found ? old_r : id_r;
    priority if (cmd.enq) begin
      wr_addr = empty_r ? '0 : tail_inc;
    end else if (cmd.wr_head) begin
      wr_addr = head_r;
    end else begin
      wr_addr = found_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
      rvld_r  <= vld_r[rd_addr];
      raddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (clear_all) begin
      vld_r <= '0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (deq_one) begin
        vld_r[head_r] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      cnt_r   <= '0;
      empty_r <= 1'b1;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      cnt_r   <= cnt_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= op_t'(in_op);
      id_r   <= in_proc_id;
      scan_r <= '0;
    end else if (cmd.rd_en && cmd.rd_scan) begin
      scan_r <= scan_r + 1'b1;
    end
    if (cmd.old_ld) begin
      old_r <= rd_word;
    end
    if (cmd.found_ld) begin
      found_r <= raddr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_count_r <= cnt_nxt;
      unique case (cmd.res)
        RES_ENQ: begin
          out_status_r <= ST_OK;
          out_value_r  <= id_r;
        end
        RES_FULL: begin
          out_status_r <= ST_FULL;
          out_value_r  <= '0;
        end
        RES_EMPTY: begin
          out_status_r <= ST_EMPTY;
          out_value_r  <= '0;
        end
        RES_HEAD: begin
          out_status_r <= ST_OK;
          out_value_r  <= rd_word;
        end
        RES_ID: begin
          out_status_r <= ST_OK;
          out_value_r  <= id_r;
        end
        RES_OLD: begin
          out_status_r <= ST_OK;
          out_value_r  <= old_r;
        end
        RES_NOTF: begin
          out_status_r <= ST_NOTFOUND;
          out_value_r  <= '0;
        end
        default: begin
          out_status_r <= ST_OK;
          out_value_r  <= '0;
        end
      endcase
    end
  end

  assign sts.op       = op_r;
  assign sts.empty    = empty_r;
  assign sts.full     = (cnt_r == CNT_W'(DEPTH));
  assign sts.one      = (cnt_r == CNT_W'(1));
  assign sts.hit      = (rd_word == id_r);
  assign sts.scan_end = (raddr_r == ADDR_W'(DEPTH - 1));

  assign out_status = out_status_r;
  assign out_value  = out_value_r;
  assign out_count  = out_count_r;

endmodule

// ===== rtl/core/cpq_ctrl.sv =====
// Controller of the circular process-id queue: sequences each operation
// and owns the handshake flags. Depends on cpq_pkg.
module cpq_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  logic                   out_ready,
  input  cpq_pkg::cpq_sts_t      sts,
  output cpq_pkg::cpq_cmd_t      cmd
);
  import cpq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_HEAD,
    S_SCAN,
    S_SWAP1,
    S_SWAP2,
    S_NOTF
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   out_free;

  assign out_free = ~out_valid_r | out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.res   = RES_ENQ;
    cmd.load  = in_valid & in_ready;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.rd_en = 1'b1;
        priority if (sts.op == OP_ENQ) begin
          if (out_free) begin
            cmd.emit  = 1'b1;
            cmd.res   = sts.full ? RES_FULL : RES_ENQ;
            cmd.enq   = ~sts.full;
            state_nxt = S_IDLE;
          end
        end else if (sts.empty) begin
          if (out_free) begin
            cmd.emit  = 1'b1;
            cmd.res   = RES_EMPTY;
            state_nxt = S_IDLE;
          end
        end else if (sts.op == OP_SWAP && sts.one) begin
          if (out_free) begin
            cmd.emit  = 1'b1;
            cmd.res   = RES_ID;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        if (sts.op == OP_SWAP) begin
          cmd.rd_en   = 1'b1;
          cmd.rd_scan = 1'b1;
          cmd.old_ld  = 1'b1;
          state_nxt   = S_SCAN;
        end else if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.res   = RES_HEAD;
          cmd.deq   = (sts.op == OP_DEQ);
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        priority if (sts.hit) begin
          cmd.found_ld = 1'b1;
          state_nxt    = S_SWAP1;
        end else if (sts.scan_end) begin
          state_nxt = S_NOTF;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_scan = 1'b1;
        end
      end
      S_SWAP1: begin
        cmd.wr_head = 1'b1;
        state_nxt   = S_SWAP2;
      end
      S_SWAP2: begin
        if (out_free) begin
          cmd.wr_found = 1'b1;
          cmd.emit     = 1'b1;
          cmd.res      = RES_OLD;
          state_nxt    = S_IDLE;
        end
      end
      S_NOTF: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          cmd.res   = RES_NOTF;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

  // A new result only goes out when the output register is free.
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> out_free)
    else $error("result emitted over an untaken word");

  // Every emitted result finishes its operation.
  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_IDLE)
    else $error("controller did not return to idle after a result");

  a_enq_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.enq |-> !sts.full)
    else $error("enqueue committed on a full queue");

  a_take_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.deq || cmd.wr_head || cmd.wr_found) |-> !sts.empty)
    else $error("dequeue or swap committed on an empty queue");

  a_accept_look: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == S_LOOK)
    else $error("accepted word not decoded");

endmodule

// ===== rtl/core/circular_pid_queue_with_swap.sv =====
// Top level of the circular process-id run queue with swap-to-head.
// Instantiates cpq_ctrl and cpq_dp; depends on cpq_pkg.
//
// Usage: each input word carries an operation (enqueue, dequeue, peek or
// swap-to-head) and a process id, and produces exactly one output word with
// a status, a returned id and the number of ids held afterward. Both
// channels use valid/ready; a word moves when valid and ready are both high.
// The block works on one word at a time: in_ready is high only while the
// controller is idle, but it does not depend on the output side, so a new
// word is taken while the previous result still waits in the output register.
// Enqueue, any operation on an empty queue and a swap with one id held are
// answered from the look state; dequeue and peek pass the head state too. A
// swap scans the slot memory one slot per cycle from slot 0, then writes the
// head in SWAP1 and the found slot in SWAP2, or reports not found once slot
// DEPTH - 1 has been read. The slot memory has a single read port.
// Reset (synchronous, active low) empties the queue and clears every slot
// through per-slot valid bits at once; no clearing pass is needed. When the
// receiver stalls, the result is held and the next operation waits at its
// final step until the output register is free.
module circular_pid_queue_with_swap (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [cpq_pkg::OP_W-1:0]  in_op,
  input  logic [cpq_pkg::ID_W-1:0]  in_proc_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [cpq_pkg::ST_W-1:0]  out_status,
  output logic [cpq_pkg::ID_W-1:0]  out_value,
  output logic [cpq_pkg::CNT_W-1:0] out_count
);
  import cpq_pkg::*;

  cpq_cmd_t cmd;
  cpq_sts_t sts;

  // The controller sequences each operation and owns both handshakes.
  cpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the slots, the queue pointers and the output word.
  cpq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_op),
    .in_proc_id (in_proc_id),
    .sts        (sts),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count)
  );

endmodule

// ===== tb/pid_queue_checker.sv =====
`timescale 1ns / 100ps
// Checker for the circular process-id queue: keeps its own copy of the queue,
// works out one result per accepted input word and compares every output word.
// Depends on cpq_pkg.
module pid_queue_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [cpq_pkg::OP_W-1:0]  in_op,
  input  logic [cpq_pkg::ID_W-1:0]  in_proc_id,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [cpq_pkg::ST_W-1:0]  out_status,
  input  logic [cpq_pkg::ID_W-1:0]  out_value,
  input  logic [cpq_pkg::CNT_W-1:0] out_count,
  output int                        mismatches,
  output int                        awaited
);
  import cpq_pkg::*;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  value;
    logic [CNT_W-1:0] count;
  } queue_result_t;

  logic [ID_W-1:0]   pid_slot [DEPTH];
  logic [ADDR_W-1:0] head_at;
  logic [ADDR_W-1:0] tail_at;
  logic [CNT_W-1:0]  held;
  logic              queue_empty;
  queue_result_t     pending_results [$];
  queue_result_t     want;

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic void clear_queue();
    for (int i = 0; i < DEPTH; i++) begin
      pid_slot[i] = '0;
    end
    head_at     = '0;
    tail_at     = '0;
    held        = '0;
    queue_empty = 1'b1;
  endfunction

  function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] at);
    return (at == ADDR_W'(DEPTH - 1)) ? '0 : at + 1'b1;
  endfunction

  // Applies one operation to the queue copy and queues the result it gives.
  function automatic void predict_result(input op_t op, input logic [ID_W-1:0] pid);
    queue_result_t   r;
    int              hit_at;
    logic [ID_W-1:0] old_head;
    r.status = ST_OK;
    r.value  = '0;
    if (op == OP_ENQ) begin
      if (held >= DEPTH) begin
        r.status = ST_FULL;
      end else begin
        if (queue_empty) begin
          head_at     = '0;
          tail_at     = '0;
          queue_empty = 1'b0;
        end else begin
          tail_at = next_slot(tail_at);
        end
        pid_slot[tail_at] = pid;
        held              = held + 1'b1;
        r.value           = pid;
      end
    end else if (queue_empty) begin
      r.status = ST_EMPTY;
    end else if (op == OP_DEQ) begin
      r.value           = pid_slot[head_at];
      pid_slot[head_at] = '0;
      if (head_at == tail_at) begin
        clear_queue();
      end else begin
        head_at = next_slot(head_at);
        if (held != 0) begin
          held = held - 1'b1;
        end
      end
    end else if (op == OP_PEEK) begin
      r.value = pid_slot[head_at];
    end else if (held == 1) begin
      // A lone id is handed back as given, with no search.
      r.value = pid;
    end else begin
      // Every slot takes part in the search, free ones included.
      hit_at = -1;
      for (int i = 0; i < DEPTH; i++) begin
        if (hit_at < 0 && pid_slot[i] == pid) begin
          hit_at = i;
        end
      end
      if (hit_at < 0) begin
        r.status = ST_NOTFOUND;
      end else begin
        old_head          = pid_slot[head_at];
        pid_slot[head_at] = pid;
        pid_slot[hit_at]  = old_head;
        r.value           = old_head;
      end
    end
    r.count = held;
    pending_results.push_back(r);
  endfunction

  initial begin
    clear_queue();
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_queue();
      pending_results.delete();
    end else begin
      // An output word taken at this edge always belongs to an earlier input
      // word, so it is checked before this edge's input word is predicted.
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("output word with none due: status %0d value %h count %0d",
                                    out_status, out_value, out_count));
        end else begin
          want = pending_results.pop_front();
          if (out_status !== want.status) begin
            report_mismatch($sformatf("status %0d, due %0d", out_status, want.status));
          end
          if (out_value !== want.value) begin
            report_mismatch($sformatf("value %h, due %h", out_value, want.value));
          end
          if (out_count !== want.count) begin
            report_mismatch($sformatf("count %0d, due %0d", out_count, want.count));
          end
        end
      end
      if (in_valid && in_ready) begin
        predict_result(op_t'(in_op), in_proc_id);
      end
    end
    awaited <= pending_results.size();
  end

endmodule

// ===== tb/circular_pid_queue_with_swap_tb.sv =====
`timescale 1ns / 100ps
// Testbench top for the circular process-id queue: drives words and stalls,
// and gives the verdict. Depends on cpq_pkg, pid_queue_checker and the block.
module circular_pid_queue_with_swap_tb;
  import cpq_pkg::*;

  // The slowest correct run is near 1050 words under heavy stalls, well under
  // a fifth of this.
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_WORDS = 345;
  localparam int POOL_SIZE   = 32;

  logic             clk;
  logic             rst_n      = 1'b0;
  logic             in_valid   = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_op      = OP_ENQ;
  logic [ID_W-1:0]  in_proc_id = '0;
  logic             out_valid;
  logic             out_ready  = 1'b0;
  logic [ST_W-1:0]  out_status;
  logic [ID_W-1:0]  out_value;
  logic [CNT_W-1:0] out_count;

  int mismatches;
  int awaited;
  int cycles     = 0;
  int words_sent = 0;
  // Chance in a hundred that the sender or the receiver idles on a cycle.
  int send_idle  = 0;
  int recv_idle  = 0;

  // Ids enqueued lately, so that most swaps find what they look for.
  logic [ID_W-1:0] recent_pids [$];

  circular_pid_queue_with_swap uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_proc_id (in_proc_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count)
  );

  pid_queue_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_proc_id (in_proc_id),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_count  (out_count),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // The receiver stalls at random, one draw per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Offers one word and returns at the edge where it is accepted. The valid
  // is lowered only while the sender idles, so back-to-back words keep it
  // high through the edge where the next payload is put out.
  task automatic send_word(input op_t op, input logic [ID_W-1:0] pid);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_op      <= op;
    in_proc_id <= pid;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    words_sent++;
    if (op == OP_ENQ) begin
      recent_pids.push_back(pid);
      if (recent_pids.size() > POOL_SIZE) begin
        void'(recent_pids.pop_front());
      end
    end
  endtask

  // Holds the sender off until every result word owed has come back. The
  // checker's count is registered, hence the edge before the first look.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited != 0) begin
      @(posedge clk);
    end
  endtask

  // Ids lean toward zero, the all-ones id and a small set that repeats, so
  // that duplicates and zero-matching free slots turn up often.
  function automatic logic [ID_W-1:0] make_pid();
    int pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      return '0;
    end else if (pick < 18) begin
      return '1;
    end else if (pick < 40) begin
      return ID_W'($urandom_range(15, 1));
    end else if (pick < 60 && recent_pids.size() != 0) begin
      return recent_pids[$urandom_range(recent_pids.size() - 1)];
    end
    return ID_W'($urandom());
  endfunction

  function automatic logic [ID_W-1:0] swap_pid();
    if ($urandom_range(99) < 60 && recent_pids.size() != 0) begin
      return recent_pids[$urandom_range(recent_pids.size() - 1)];
    end
    return make_pid();
  endfunction

  // Operation mix for a run of words: the queue tends to grow, hold or shrink.
  function automatic op_t pick_op(input int trend);
    int pick;
    int enq_w;
    int deq_w;
    pick  = $urandom_range(99);
    enq_w = (trend == 0) ? 60 : (trend == 1) ? 35 : 15;
    deq_w = (trend == 0) ? 15 : (trend == 1) ? 30 : 55;
    if (pick < enq_w) begin
      return OP_ENQ;
    end else if (pick < enq_w + deq_w) begin
      return OP_DEQ;
    end else if (pick < enq_w + deq_w + 10) begin
      return OP_PEEK;
    end
    return OP_SWAP;
  endfunction

  // One random phase under the given idling. It opens by filling the queue
  // past full, then moves through runs that grow, hold or shrink it, which
  // carries the head and tail around the ring and empties it now and then.
  task automatic run_phase(input int sender_idle, input int receiver_idle, input int words);
    int   target;
    int   trend;
    op_t  op;
    send_idle = sender_idle;
    recv_idle = receiver_idle;
    target    = words_sent + words;
    repeat (DEPTH + 2) begin
      send_word(OP_ENQ, make_pid());
    end
    while (words_sent < target) begin
      trend = $urandom_range(2);
      repeat ($urandom_range(40, 1)) begin
        op = pick_op(trend);
        send_word(op, (op == OP_SWAP) ? swap_pid() : make_pid());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, without idling on the sender side.
    send_word(OP_PEEK, ID_W'(9));           // Every operation but enqueue
    send_word(OP_DEQ,  '1);                 // on an empty queue reports empty.
    send_word(OP_SWAP, ID_W'(5));
    send_word(OP_ENQ,  31'h7FFF_FFFF);
    send_word(OP_SWAP, ID_W'(123));         // One id held: given id comes back.
    send_word(OP_PEEK, '0);
    send_word(OP_DEQ,  '0);                 // Last id leaves and clears all.
    send_word(OP_ENQ,  '0);
    send_word(OP_ENQ,  31'h2AAA_AAAA);
    send_word(OP_ENQ,  31'h5555_5555);
    send_word(OP_SWAP, 31'h5555_5555);      // Found behind the head.
    send_word(OP_SWAP, 31'h5555_5555);      // Found at the head itself.
    send_word(OP_SWAP, ID_W'(7));           // Not found anywhere.
    send_word(OP_SWAP, '0);                 // Zero found in an occupied slot.
    send_word(OP_DEQ,  '0);
    send_word(OP_DEQ,  '0);
    send_word(OP_ENQ,  ID_W'(1));
    send_word(OP_SWAP, '0);                 // Zero matches a freed slot.
    send_word(OP_PEEK, '0);
    send_word(OP_DEQ,  '0);
    send_word(OP_DEQ,  '0);
    send_word(OP_DEQ,  '0);
    wait_drained();

    // Random part: the receiver idles more first, then the sender, then
    // neither. The sender waits for every result between phases.
    run_phase(35, 65, PHASE_WORDS);
    wait_drained();
    run_phase(65, 35, PHASE_WORDS);
    wait_drained();
    run_phase(0, 0, PHASE_WORDS);

    // A swap that misses scans all DEPTH slots, so allow for that before
    // looking for stray words after the last one due.
    wait_drained();
    repeat (DEPTH + 16) @(posedge clk);
    if (mismatches == 0 && awaited == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
